/* hdl/ssc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants, register indexes and types for the signature scanner.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int DEF_MAX_PATTERN = 8;
    localparam int DEF_MAX_WINDOW  = 32;
    localparam int DEF_OFFSET_BITS = 20;

    localparam int BYTE_W      = 8;
    localparam int PAT_W       = 64;
    localparam int PLEN_W      = 4;
    localparam int CLEN_W      = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CLEN_W-1:0] CHECK_LENGTH_RESET = 6'd20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_CHECK_ENABLE   = 2'd2,
        REG_CHECK_LENGTH   = 2'd3
    } cfg_index_t;

    // Configuration as seen by the datapath, lengths already saturated
    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [PLEN_W-1:0] plen;
        logic              chk_en;
        logic [CLEN_W-1:0] clen;
        logic [CLEN_W-1:0] delay;   // bytes from match start to newest byte
    } cfg_t;

    // Input stage status
    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

endpackage

/* hdl/ssc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_in_if
// Byte stream channel: one scanned byte per item plus end-of-region mark.
// ----------------------------------------------------------------------------
interface ssc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ssc_pkg::BYTE_W-1:0]  data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/ssc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_out_if
// Result channel: one item per region, found flag and match offset.
// ----------------------------------------------------------------------------
interface ssc_out_if #(
    parameter int OFFSET_BITS = ssc_pkg::DEF_OFFSET_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [OFFSET_BITS-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* hdl/signature_scan_with_checksum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_scan_with_checksum
// Byte pattern search per region with optional zero byte-sum qualification.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : one byte per item; last_byte marks the final byte of a region.
//   result : one item per region, found with the match start offset at the
//            first qualifying match, or found clear at the region's last byte.
//   cfg_*  : write-only registers (pattern bytes, pattern length, check enable,
//            check length); write them while no item is in flight.
// Timing:
//   An accepted byte sits in the input stage register while the pattern
//   compare and byte-sum tree decide; any result it gives then enters the
//   output register. One byte per cycle sustained unless result stalls; the
//   single-pass compare/sum between the stage and result registers sets it.
// Reset clears the stage, the byte counter, the done flag and the result
// register; configuration returns to its reset values. The delay line holds
// stale bytes until refilled, which no candidate reads.
// When result is stalled the input stage keeps taking bytes that give no
// result; it holds only a byte whose result cannot enter the result register.
// ----------------------------------------------------------------------------
module signature_scan_with_checksum #(
    parameter int MAX_PATTERN = ssc_pkg::DEF_MAX_PATTERN,
    parameter int MAX_WINDOW  = ssc_pkg::DEF_MAX_WINDOW,
    parameter int OFFSET_BITS = ssc_pkg::DEF_OFFSET_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    ssc_in_if.sink                           scan,
    ssc_out_if.source                        result
);

    ssc_pkg::cfg_t              cfg;
    ssc_pkg::stage_t            stage;
    logic [ssc_pkg::BYTE_W-1:0] taps [MAX_WINDOW];
    logic                       accept;
    logic                       advance;
    logic                       hit;
    logic                       done;
    logic [OFFSET_BITS-1:0]     start;
    logic [OFFSET_BITS-1:0]     count;

    assign scan.ready = !stage.valid || advance;
    assign accept     = scan.valid && scan.ready;

    ssc_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ssc_line #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .data_byte (scan.data_byte),
        .last_byte (scan.last_byte),
        .stage     (stage),
        .taps      (taps)
    );

    ssc_match #(
        .MAX_WINDOW  (MAX_WINDOW),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .cfg   (cfg),
        .taps  (taps),
        .count (count),
        .done  (done),
        .hit   (hit),
        .start (start)
    );

    ssc_ctrl #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .hit        (hit),
        .start      (start),
        .out_ready  (result.ready),
        .advance    (advance),
        .count      (count),
        .done       (done),
        .out_valid  (result.valid),
        .out_found  (result.found),
        .out_offset (result.match_offset)
    );

endmodule

/* hdl/ssc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_cfg
// Configuration registers with length saturation and window delay derivation.
// ----------------------------------------------------------------------------
module ssc_cfg #(
    parameter int MAX_PATTERN = ssc_pkg::DEF_MAX_PATTERN,
    parameter int MAX_WINDOW  = ssc_pkg::DEF_MAX_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ssc_pkg::cfg_t                    cfg
);

    logic [ssc_pkg::PAT_W-1:0]  pattern_reg;
    logic [ssc_pkg::PLEN_W-1:0] plen_reg;
    logic                       chk_en_reg;
    logic [ssc_pkg::CLEN_W-1:0] clen_reg;

    logic [ssc_pkg::PLEN_W-1:0] plen_sat;
    logic [ssc_pkg::CLEN_W-1:0] clen_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= '0;
            chk_en_reg  <= 1'b0;
            clen_reg    <= ssc_pkg::CHECK_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (ssc_pkg::cfg_index_t'(cfg_index))
                ssc_pkg::REG_PATTERN_BYTES:  pattern_reg <= cfg_wdata[ssc_pkg::PAT_W-1:0];
                ssc_pkg::REG_PATTERN_LENGTH: plen_reg    <= cfg_wdata[ssc_pkg::PLEN_W-1:0];
                ssc_pkg::REG_CHECK_ENABLE:   chk_en_reg  <= cfg_wdata[0];
                ssc_pkg::REG_CHECK_LENGTH:   clen_reg    <= cfg_wdata[ssc_pkg::CLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        plen_sat = (int'(plen_reg) > MAX_PATTERN) ? ssc_pkg::PLEN_W'(MAX_PATTERN) : plen_reg;
        clen_sat = (int'(clen_reg) > MAX_WINDOW) ? ssc_pkg::CLEN_W'(MAX_WINDOW) : clen_reg;

        cfg.pattern = pattern_reg;
        cfg.plen    = plen_sat;
        cfg.chk_en  = chk_en_reg;
        cfg.clen    = clen_sat;
        // Pattern and check window share the start; with the check on the longer one sets the delay
        if (chk_en_reg && (clen_sat > ssc_pkg::CLEN_W'(plen_sat)))
            cfg.delay = clen_sat;
        else
            cfg.delay = ssc_pkg::CLEN_W'(plen_sat);
    end

endmodule

/* hdl/ssc_line.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_line
// Input stage register and byte delay line, tap 0 holds the newest byte.
// ----------------------------------------------------------------------------
module ssc_line #(
    parameter int MAX_WINDOW = ssc_pkg::DEF_MAX_WINDOW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        advance,
    input  logic [ssc_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    output ssc_pkg::stage_t             stage,
    output logic [ssc_pkg::BYTE_W-1:0]  taps [MAX_WINDOW]
);

    logic [ssc_pkg::BYTE_W-1:0] line_reg [MAX_WINDOW];
    logic                       valid_reg;
    logic                       valid_next;
    logic                       last_reg;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg    <= last_byte;
            line_reg[0] <= data_byte;
            for (int k = 1; k < MAX_WINDOW; k++)
                line_reg[k] <= line_reg[k-1];
        end
    end

    assign stage.valid = valid_reg;
    assign stage.last  = last_reg;
    assign taps        = line_reg;

endmodule

/* hdl/ssc_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_match
// Candidate evaluation: per-tap pattern compare and masked byte-sum tree.
// ----------------------------------------------------------------------------
module ssc_match #(
    parameter int MAX_WINDOW  = ssc_pkg::DEF_MAX_WINDOW,
    parameter int OFFSET_BITS = ssc_pkg::DEF_OFFSET_BITS
) (
    input  ssc_pkg::cfg_t               cfg,
    input  logic [ssc_pkg::BYTE_W-1:0]  taps [MAX_WINDOW],
    input  logic [OFFSET_BITS-1:0]      count,
    input  logic                        done,
    output logic                        hit,
    output logic [OFFSET_BITS-1:0]      start
);

    localparam int LV = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NP = 1 << LV;

    logic [ssc_pkg::BYTE_W-1:0] tree [LV+1][NP];
    logic [MAX_WINDOW-1:0]      pat_fail;
    logic [OFFSET_BITS-1:0]     received;
    logic                       evaluate;
    logic                       check_ok;

    // Tap j holds pattern byte delay-1-j when it lies in the pattern span
    always_comb
    begin
        logic [ssc_pkg::CLEN_W-1:0] diff;
        logic                       in_pat;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            diff   = cfg.delay - ssc_pkg::CLEN_W'(j + 1);
            in_pat = (j < int'(cfg.delay)) && ((j + int'(cfg.plen)) >= int'(cfg.delay));
            pat_fail[j] = in_pat && (taps[j] != cfg.pattern[ssc_pkg::BYTE_W*diff[2:0] +: ssc_pkg::BYTE_W]);
        end
    end

    // Check window covers taps delay-clen .. delay-1; sum is mod 256
    always_comb
    begin
        tree = '{default: '0};
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            if (cfg.chk_en && (j < int'(cfg.delay)) && ((j + int'(cfg.clen)) >= int'(cfg.delay)))
                tree[0][j] = taps[j];
        end
        for (int l = 1; l <= LV; l++)
        begin
            for (int k = 0; k < (NP >> l); k++)
                tree[l][k] = tree[l-1][2*k] + tree[l-1][2*k+1];
        end
    end

    always_comb
    begin
        received = count + OFFSET_BITS'(1);
        evaluate = !done && (cfg.plen != '0) && (count != '1)
                   && (received >= OFFSET_BITS'(cfg.delay));
        check_ok = !cfg.chk_en || (tree[LV][0] == '0);
        hit      = evaluate && (pat_fail == '0) && check_ok;
        start    = received - OFFSET_BITS'(cfg.delay);
    end

endmodule

/* hdl/ssc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_ctrl
// Region control: byte counter, done flag, result register and stage advance.
// ----------------------------------------------------------------------------
module ssc_ctrl #(
    parameter int OFFSET_BITS = ssc_pkg::DEF_OFFSET_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ssc_pkg::stage_t         stage,
    input  logic                    hit,
    input  logic [OFFSET_BITS-1:0]  start,
    input  logic                    out_ready,
    output logic                    advance,
    output logic [OFFSET_BITS-1:0]  count,
    output logic                    done,
    output logic                    out_valid,
    output logic                    out_found,
    output logic [OFFSET_BITS-1:0]  out_offset
);

    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   emit;
    logic                   slot_free;

    always_comb
    begin
        // One item per region: first hit, or the last byte if nothing was given
        emit      = stage.valid && (hit || (stage.last && !done_reg));
        slot_free = !out_valid_reg || out_ready;
        advance   = stage.valid && (!emit || slot_free);

        count_next     = count_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
        begin
            if (stage.last)
            begin
                count_next = '0;
                done_next  = 1'b0;
            end
            else
            begin
                if (count_reg != '1)
                    count_next = count_reg + OFFSET_BITS'(1);
                if (hit)
                    done_next = 1'b1;
            end
            if (emit)
                out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            found_reg  <= hit;
            offset_reg <= hit ? start : '0;
        end
    end

    assign count      = count_reg;
    assign done       = done_reg;
    assign out_valid  = out_valid_reg;
    assign out_found  = found_reg;
    assign out_offset = offset_reg;

endmodule

/* hdl/ssc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the signature scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ssc_checker #(
    parameter int OFFSET_BITS = ssc_pkg::DEF_OFFSET_BITS
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   scan_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic                   result_found,
    input logic [OFFSET_BITS-1:0] result_match_offset
);

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_found)
            && $stable(result_match_offset))
        else $error("result item changed while stalled");

    // A no-match item carries a zero offset
    a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_found |-> result_match_offset == '0)
        else $error("miss item with nonzero offset");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // With the result register empty the scanner always takes a byte
    a_ready_free: assert property (@(posedge clk)
        !result_valid |-> scan_ready)
        else $error("scan stalled with empty result register");

endmodule

bind signature_scan_with_checksum ssc_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_ssc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .scan_ready          (scan.ready),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_found        (result.found),
    .result_match_offset (result.match_offset)
);

/* tb/signature_scan_with_checksum_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_scan_with_checksum_test
// Self-checking bench for the signature scanner. Byte regions go in on the
// scan channel; a local scanner model predicts the one result item of each
// region and a checker compares every result item field by field. Directed
// cases cover the length saturations, the empty check window and a setup
// change inside a region; random regions with planted patterns and fixed-up
// checksums follow under three idling mixes.
// ----------------------------------------------------------------------------
module signature_scan_with_checksum_test;

    localparam int BYTE_W       = ssc_pkg::BYTE_W;
    localparam int PAT_W        = ssc_pkg::PAT_W;
    localparam int PLEN_W       = ssc_pkg::PLEN_W;
    localparam int CLEN_W       = ssc_pkg::CLEN_W;
    localparam int CFG_DATA_W   = ssc_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W  = ssc_pkg::CFG_INDEX_W;
    localparam int SCAN_WINDOW  = ssc_pkg::DEF_MAX_WINDOW;
    localparam int PAT_MAX      = ssc_pkg::DEF_MAX_PATTERN;
    localparam int OFS_W        = ssc_pkg::DEF_OFFSET_BITS;
    localparam logic [OFS_W-1:0] OFFSET_CEIL = '1;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] offset;
    } scan_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    ssc_in_if scan_ch ();
    ssc_out_if #(.OFFSET_BITS(OFS_W)) result_ch ();

    signature_scan_with_checksum i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .scan      (scan_ch),
        .result    (result_ch)
    );

    // scanner model: setup registers and region state
    logic [PAT_W-1:0]  pattern_q;
    logic [PLEN_W-1:0] plen_q;
    logic              chk_en_q;
    logic [CLEN_W-1:0] clen_q;
    logic [BYTE_W-1:0] history [SCAN_WINDOW];
    logic [OFS_W-1:0]  region_count;
    logic              region_done;

    scan_result_t      region_results [$];
    logic [BYTE_W-1:0] region_bytes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int regions_checked = 0;
    int matches_seen = 0;
    int bytes_sent = 0;
    int stall_cycles = 0;

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one scanned byte; queues the region result it closes or matches
    function automatic void predict_scan_byte(input logic [BYTE_W-1:0] data,
                                              input logic last);
        int           plen;
        int           clen;
        int           span;
        int           received;
        int           sum;
        logic         hit;
        scan_result_t res;
        plen = (int'(plen_q) > PAT_MAX) ? PAT_MAX : int'(plen_q);
        clen = (int'(clen_q) > SCAN_WINDOW) ? SCAN_WINDOW : int'(clen_q);
        span = (chk_en_q && clen > plen) ? clen : plen;
        for (int i = SCAN_WINDOW - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = data;
        hit = 1'b0;
        res.offset = '0;
        received = int'(region_count) + 1;
        if (!region_done && plen != 0 && region_count != OFFSET_CEIL && received >= span)
        begin
            hit = 1'b1;
            res.offset = OFS_W'(received - span);
            for (int i = 0; i < plen; i++)
                if (history[span-1-i] != pattern_q[8*i +: 8])
                    hit = 1'b0;
            if (chk_en_q)
            begin
                sum = 0;
                for (int i = 0; i < clen; i++)
                    sum += int'(history[span-1-i]);
                if (sum % 256 != 0)
                    hit = 1'b0;
            end
        end
        if (region_count != OFFSET_CEIL)
            region_count++;
        res.found = hit;
        if (!hit)
            res.offset = '0;
        if (hit || (last && !region_done))
            region_results.push_back(res);
        if (last)
        begin
            region_count = '0;
            region_done = 1'b0;
        end
        else if (hit)
            region_done = 1'b1;
    endfunction

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
        begin
            if (region_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result item with none expected: found=%0b offset=%0d",
                             $time, result_ch.found, result_ch.match_offset);
            end
            else
            begin
                if (result_ch.found !== region_results[0].found ||
                    result_ch.match_offset !== region_results[0].offset)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] result mismatch: expected found=%0b offset=%0d,",
                                  " got found=%0b offset=%0d"},
                                 $time, region_results[0].found, region_results[0].offset,
                                 result_ch.found, result_ch.match_offset);
                end
                if (region_results[0].found)
                    matches_seen++;
                regions_checked++;
                void'(region_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((scan_ch.valid && scan_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, region_results.size());
            $display("FAIL signature_scan_with_checksum");
            $finish;
        end
    end

    task automatic write_cfg(input ssc_pkg::cfg_index_t idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // write all four registers; upper write-data bits beyond a register are dropped
    task automatic load_scan_setup(input logic [CFG_DATA_W-1:0] pattern,
                                   input logic [CFG_DATA_W-1:0] plen,
                                   input logic [CFG_DATA_W-1:0] chk_en,
                                   input logic [CFG_DATA_W-1:0] clen);
        write_cfg(ssc_pkg::REG_PATTERN_BYTES, pattern);
        write_cfg(ssc_pkg::REG_PATTERN_LENGTH, plen);
        write_cfg(ssc_pkg::REG_CHECK_ENABLE, chk_en);
        write_cfg(ssc_pkg::REG_CHECK_LENGTH, clen);
        cfg_we <= 1'b0;
        pattern_q = pattern;
        plen_q = plen[PLEN_W-1:0];
        chk_en_q = chk_en[0];
        clen_q = clen[CLEN_W-1:0];
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            scan_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        scan_ch.valid <= 1'b1;
        scan_ch.data_byte <= data;
        scan_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        predict_scan_byte(data, last);
        bytes_sent++;
    endtask

    task automatic send_region(input logic close);
        for (int i = 0; i < region_bytes.size(); i++)
            push_byte(region_bytes[i], close && i == region_bytes.size() - 1);
    endtask

    // block is idle once every result is in and the stage has emptied
    task automatic drain_results();
        scan_ch.valid <= 1'b0;
        while (region_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_zero_pattern_length();
        // reset setup has length zero, so even a zero byte never matches
        region_bytes.delete();
        region_bytes.push_back(8'h00);
        region_bytes.push_back(8'hFF);
        send_region(1'b1);
        drain_results();
    endtask

    task automatic test_long_pattern_saturates();
        // length 15 acts as 8; match lands on the closing byte
        load_scan_setup('1, 64'd15, 64'd0, 64'd20);
        region_bytes.delete();
        repeat (8) region_bytes.push_back(8'hFF);
        send_region(1'b1);
        drain_results();
    endtask

    task automatic test_empty_check_window();
        // zero check length always passes; the trailing byte stays silent
        load_scan_setup(64'h0, 64'd1, 64'd1, 64'd0);
        region_bytes.delete();
        region_bytes.push_back(8'h00);
        region_bytes.push_back(8'h7F);
        send_region(1'b1);
        drain_results();
    endtask

    task automatic test_check_window_saturates();
        // length 63 acts as 32: 0x80 + 0x80 over 32 bytes wraps to zero
        load_scan_setup(64'h80, 64'd1, 64'd1, 64'd63);
        region_bytes.delete();
        region_bytes.push_back(8'h80);
        region_bytes.push_back(8'h80);
        repeat (30) region_bytes.push_back(8'h00);
        region_bytes.push_back(8'h01);
        send_region(1'b1);
        drain_results();
    endtask

    task automatic test_setup_change_mid_region();
        // pattern straddles the write: bytes before it still count
        load_scan_setup(64'hBBAA, 64'd0, 64'd0, 64'd20);
        region_bytes.delete();
        region_bytes.push_back(8'h00);
        region_bytes.push_back(8'hAA);
        send_region(1'b0);
        drain_results();
        load_scan_setup(64'hBBAA, 64'd2, 64'd0, 64'd20);
        push_byte(8'hBB, 1'b1);
        drain_results();
    endtask

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] pattern;
        logic [CFG_DATA_W-1:0] plen;
        logic [CFG_DATA_W-1:0] chk_en;
        logic [CFG_DATA_W-1:0] clen;
        logic [CFG_DATA_W-1:0] junk;
        case ($urandom_range(0, 5))
            0: pattern = '0;
            1: pattern = '1;
            default: pattern = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 9))
            0: plen = '0;
            1: plen = CFG_DATA_W'($urandom_range(PAT_MAX + 1, 15));
            default: plen = CFG_DATA_W'($urandom_range(1, PAT_MAX));
        endcase
        chk_en = CFG_DATA_W'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: clen = '0;
            1: clen = CFG_DATA_W'($urandom_range(SCAN_WINDOW + 1, 63));
            2: clen = CFG_DATA_W'(SCAN_WINDOW);
            3: clen = CFG_DATA_W'(1);
            default: clen = CFG_DATA_W'($urandom_range(2, SCAN_WINDOW - 1));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            junk = {$urandom, $urandom};
            plen = {junk[CFG_DATA_W-1:PLEN_W], plen[PLEN_W-1:0]};
            junk = {$urandom, $urandom};
            chk_en = {junk[CFG_DATA_W-1:1], chk_en[0]};
            junk = {$urandom, $urandom};
            clen = {junk[CFG_DATA_W-1:CLEN_W], clen[CLEN_W-1:0]};
        end
        load_scan_setup(pattern, plen, chk_en, clen);
    endtask

    // mostly a planted pattern with a zero-sum window; some noise, some near misses
    task automatic random_region();
        int                plen;
        int                clen;
        int                span;
        int                len;
        int                pos;
        int                sum;
        int                kind;
        logic [BYTE_W-1:0] data;
        plen = (int'(plen_q) > PAT_MAX) ? PAT_MAX : int'(plen_q);
        clen = (int'(clen_q) > SCAN_WINDOW) ? SCAN_WINDOW : int'(clen_q);
        span = (chk_en_q && clen > plen) ? clen : plen;
        kind = int'($urandom_range(0, 9));
        if ($urandom_range(0, 19) == 0)
            len = int'($urandom_range(1, 120));
        else
            len = span + int'($urandom_range(1, 12));
        region_bytes.delete();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 1))
                data = pattern_q[8*$urandom_range(0, PAT_MAX - 1) +: 8];
            else
                data = BYTE_W'($urandom_range(0, 255));
            region_bytes.push_back(data);
        end
        if (kind >= 2 && plen != 0 && len >= span)
        begin
            pos = int'($urandom_range(0, len - span));
            for (int i = 0; i < plen; i++)
                region_bytes[pos+i] = pattern_q[8*i +: 8];
            if (chk_en_q && clen > plen)
            begin
                sum = 0;
                for (int i = 0; i < clen - 1; i++)
                    sum += int'(region_bytes[pos+i]);
                data = BYTE_W'(256 - sum % 256);
                region_bytes[pos+clen-1] = data;
            end
            if (kind == 2)
            begin
                pos = pos + int'($urandom_range(0, span - 1));
                data = 8'h01 << $urandom_range(0, 7);
                region_bytes[pos] = region_bytes[pos] ^ data;
            end
        end
        send_region(1'b1);
    endtask

    task automatic test_random_regions(input int send_pct, input int recv_pct, input int budget);
        int first;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = bytes_sent;
        while (bytes_sent - first < budget)
        begin
            drain_results();
            random_setup();
            repeat ($urandom_range(3, 8)) random_region();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= ssc_pkg::REG_PATTERN_BYTES;
        cfg_wdata <= '0;
        scan_ch.valid <= 1'b0;
        scan_ch.data_byte <= '0;
        scan_ch.last_byte <= 1'b0;
        pattern_q = '0;
        plen_q = '0;
        chk_en_q = 1'b0;
        clen_q = ssc_pkg::CHECK_LENGTH_RESET;
        foreach (history[i])
            history[i] = '0;
        region_count = '0;
        region_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 71;
        test_zero_pattern_length();
        test_long_pattern_saturates();
        test_empty_check_window();
        test_check_window_saturates();
        test_setup_change_mid_region();

        test_random_regions(19, 71, 700);
        test_random_regions(71, 19, 700);
        test_random_regions(0, 0, 600);

        $display("Scanned %0d bytes in %0d regions; %0d result items reported a match.",
                 bytes_sent, regions_checked, matches_seen);
        $display("Included length saturation, empty and full check windows and a setup"
                 , " change inside a region.");
        if (mismatches == 0)
            $display("PASS signature_scan_with_checksum");
        else
        begin
            $display("%0d result mismatches", mismatches);
            $display("FAIL signature_scan_with_checksum");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/ssc_pkg.sv
hdl/ssc_in_if.sv
hdl/ssc_out_if.sv
hdl/ssc_cfg.sv
hdl/ssc_line.sv
hdl/ssc_match.sv
hdl/ssc_ctrl.sv
hdl/signature_scan_with_checksum.sv
hdl/ssc_checker.sv
tb/signature_scan_with_checksum_test.sv
